// ----- design/chained_hash_table_core_defines.svh -----
// Assertion shorthands for the checked top module
`ifndef CHAINED_HASH_TABLE_CORE_DEFINES_SVH
`define CHAINED_HASH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, idle during reset
`define CHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, idle during reset
`define CHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/cht_pkg.sv -----
package cht_pkg;

    localparam int NUM_BUCKETS  = 8;
    localparam int BUCKET_DEPTH = 8;
    localparam int MAX_RESULTS  = 64;
    localparam int TOTAL_SLOTS  = NUM_BUCKETS * BUCKET_DEPTH;

    localparam int KEY_W      = 32;
    localparam int SCORE_W    = 16;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int BKT_W  = $clog2(NUM_BUCKETS);
    localparam int BKTC_W = $clog2(NUM_BUCKETS + 1);
    localparam int SLOT_W = $clog2(BUCKET_DEPTH + 1);
    localparam int ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

    localparam bit NB_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

    // Bucket hash for a non power of two bucket count: one nibble per step
    localparam int HASH_DIG_W = 4;
    localparam int HASH_STEPS = KEY_W / HASH_DIG_W;
    localparam int HCNT_W     = $clog2(HASH_STEPS + 1);
    localparam int HREM_W     = BKTC_W + HASH_DIG_W;

    localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_DELETE = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_LOOKUP = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_SCAN   = CMD_W'(3);

    localparam logic [STATUS_W-1:0] STATUS_OK        = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_FULL      = STATUS_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCORE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SCORE = CFG_IDX_W'(1);

    localparam logic [SCORE_W-1:0] MIN_SCORE_RST = SCORE_W'(80);
    localparam logic [SCORE_W-1:0] MAX_SCORE_RST = SCORE_W'(90);

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    found_key;
        logic [SCORE_W-1:0]  found_score;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_INS,
        S_FIND_RD,
        S_FIND_CMP,
        S_MISS,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SCAN_END
    } t_state;

    typedef enum logic [2:0] {
        EM_OK,
        EM_FULL,
        EM_MISS,
        EM_RDATA,
        EM_PEND_MID,
        EM_PEND_LAST
    } t_emit_sel;

    typedef struct packed {
        logic      accept;
        logic      hash_step;
        logic      ins_write;
        logic      rd_slot;
        logic      rd_next;
        logic      shift_wr;
        logic      slot_inc;
        logic      bkt_next;
        logic      fill_dec;
        logic      pend_load;
        logic      emit;
        t_emit_sel emit_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             hash_done;
        logic             slot_lt_fill;
        logic             next_lt_fill;
        logic             fill_full;
        logic             key_match;
        logic             score_in_range;
        logic             scan_done;
        logic             pend_valid;
        logic             cnt_last;
        logic             out_free;
    } t_dp_stat;

    // One hash step: remainder := (remainder * 16 + digit) mod NUM_BUCKETS
    function automatic logic [HREM_W-1:0] hash_step_fn(
        input logic [HREM_W-1:0]     rem,
        input logic [HASH_DIG_W-1:0] dig
    );
        logic [HREM_W-1:0] t;
        logic [HREM_W-1:0] sub;
        t = {rem[BKTC_W-1:0], dig};
        for (int k = HASH_DIG_W - 1; k >= 0; k--) begin
            sub = HREM_W'(NUM_BUCKETS) << k;
            if (t >= sub) begin
                t = t - sub;
            end
        end
        return t;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(
        input logic [BKT_W-1:0]  bkt,
        input logic [SLOT_W-1:0] slot
    );
        return ADDR_W'(bkt) * ADDR_W'(BUCKET_DEPTH) + ADDR_W'(slot);
    endfunction

endpackage

// ----- design/cht_ctrl.sv -----
module cht_ctrl import cht_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_cmd,
    output logic             o_in_ready,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = (i_in_cmd == CMD_SCAN) ? S_SCAN_RD : S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.hash_done) begin
                    n_state = (i_stat.cmd == CMD_INSERT) ? S_INS : S_FIND_RD;
                end else begin
                    o_cmd.hash_step = 1'b1;
                end
            end
            S_INS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.fill_full) begin
                        o_cmd.emit_sel = EM_FULL;
                    end else begin
                        o_cmd.ins_write = 1'b1;
                        o_cmd.emit_sel  = EM_OK;
                    end
                    n_state = S_IDLE;
                end
            end
            S_FIND_RD: begin
                if (i_stat.slot_lt_fill) begin
                    o_cmd.rd_slot = 1'b1;
                    n_state       = S_FIND_CMP;
                end else begin
                    n_state = S_MISS;
                end
            end
            S_FIND_CMP: begin
                if (i_stat.key_match) begin
                    // hold the read data until the hit can be sent
                    if (i_stat.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EM_RDATA;
                        n_state = (i_stat.cmd == CMD_DELETE) ? S_SHIFT_RD : S_IDLE;
                    end
                end else begin
                    o_cmd.slot_inc = 1'b1;
                    n_state        = S_FIND_RD;
                end
            end
            S_MISS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_MISS;
                    n_state        = S_IDLE;
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.next_lt_fill) begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_SHIFT_WR;
                end else begin
                    o_cmd.fill_dec = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.slot_inc = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_SCAN_RD: begin
                if (i_stat.scan_done) begin
                    n_state = S_SCAN_END;
                end else if (i_stat.slot_lt_fill) begin
                    o_cmd.rd_slot = 1'b1;
                    n_state       = S_SCAN_CMP;
                end else begin
                    o_cmd.bkt_next = 1'b1;
                end
            end
            S_SCAN_CMP: begin
                if (i_stat.score_in_range) begin
                    // a held match goes out as not last only once a later one proves it is not last
                    if (!i_stat.pend_valid || i_stat.out_free) begin
                        if (i_stat.pend_valid) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_sel = EM_PEND_MID;
                        end
                        o_cmd.pend_load = 1'b1;
                        if (i_stat.cnt_last) begin
                            n_state = S_SCAN_END;
                        end else begin
                            o_cmd.slot_inc = 1'b1;
                            n_state        = S_SCAN_RD;
                        end
                    end
                end else begin
                    o_cmd.slot_inc = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_SCAN_END: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = i_stat.pend_valid ? EM_PEND_LAST : EM_MISS;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/cht_dp.sv -----
module cht_dp import cht_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_in,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out
);

    t_entry r_mem [TOTAL_SLOTS];
    t_entry r_rdata;

    logic [SLOT_W-1:0] r_fill [NUM_BUCKETS];

    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_W-1:0]      r_key;
    logic [SCORE_W-1:0]    r_score;
    logic [BKTC_W-1:0]     r_bkt;
    logic [SLOT_W-1:0]     r_slot;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_pend_valid;
    t_entry                r_pend;
    logic [SCORE_W-1:0]    r_min;
    logic [SCORE_W-1:0]    r_max;
    logic [KEY_W-1:0]      r_hkey;
    logic [HREM_W-1:0]     r_hrem;
    logic [HCNT_W-1:0]     r_hcnt;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [BKT_W-1:0]  bkt_idx;
    logic [SLOT_W-1:0] fill_cur;
    logic [SLOT_W-1:0] slot_next;
    logic [SLOT_W-1:0] rd_slot;
    logic [SLOT_W-1:0] wr_slot;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              mem_wr;
    t_entry            wr_data;
    logic [HREM_W-1:0] hrem_next;
    logic              out_free;
    t_out_item         n_out;

    assign bkt_idx   = r_bkt[BKT_W-1:0];
    assign fill_cur  = r_fill[bkt_idx];
    assign slot_next = r_slot + SLOT_W'(1);
    assign rd_slot   = i_cmd.rd_next ? slot_next : r_slot;
    assign wr_slot   = i_cmd.ins_write ? fill_cur : r_slot;
    assign rd_addr   = slot_addr(bkt_idx, rd_slot);
    assign wr_addr   = slot_addr(bkt_idx, wr_slot);
    assign mem_wr    = i_cmd.ins_write || i_cmd.shift_wr;
    assign wr_data   = i_cmd.ins_write ? t_entry'{key: r_key, score: r_score} : r_rdata;
    assign hrem_next = hash_step_fn(r_hrem, r_hkey[KEY_W-1 -: HASH_DIG_W]);
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        o_stat.cmd            = r_cmd;
        o_stat.hash_done      = NB_POW2 || (r_hcnt == HCNT_W'(HASH_STEPS));
        o_stat.slot_lt_fill   = (r_slot < fill_cur);
        o_stat.next_lt_fill   = ({1'b0, r_slot} + (SLOT_W+1)'(1)) < {1'b0, fill_cur};
        o_stat.fill_full      = (fill_cur >= SLOT_W'(BUCKET_DEPTH));
        o_stat.key_match      = (r_rdata.key == r_key);
        o_stat.score_in_range = (r_rdata.score >= r_min) && (r_rdata.score <= r_max);
        o_stat.scan_done      = (r_bkt == BKTC_W'(NUM_BUCKETS));
        o_stat.pend_valid     = r_pend_valid;
        o_stat.cnt_last       = (r_cnt == CNT_W'(MAX_RESULTS - 1));
        o_stat.out_free       = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_slot || i_cmd.rd_next) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                r_fill[b] <= '0;
            end
        end else if (i_cmd.ins_write) begin
            r_fill[bkt_idx] <= fill_cur + SLOT_W'(1);
        end else if (i_cmd.fill_dec) begin
            r_fill[bkt_idx] <= fill_cur - SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_SCORE_RST;
            r_max <= MAX_SCORE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_SCORE: r_min <= i_cfg_data;
                CFG_MAX_SCORE: r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Command, bucket and slot walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd   <= i_in.cmd;
            r_key   <= i_in.key;
            r_score <= i_in.score;
            r_hkey  <= i_in.key;
            r_hrem  <= '0;
            r_hcnt  <= '0;
            r_slot  <= '0;
            r_cnt   <= '0;
            if (i_in.cmd == CMD_SCAN) begin
                r_bkt <= '0;
            end else if (NB_POW2) begin
                r_bkt <= BKTC_W'(i_in.key[BKT_W-1:0]);
            end else begin
                r_bkt <= '0;
            end
        end else begin
            if (i_cmd.hash_step) begin
                r_hrem <= hrem_next;
                r_hkey <= r_hkey << HASH_DIG_W;
                r_hcnt <= r_hcnt + HCNT_W'(1);
                if (r_hcnt == HCNT_W'(HASH_STEPS - 1)) begin
                    r_bkt <= hrem_next[BKTC_W-1:0];
                end
            end
            if (i_cmd.bkt_next) begin
                r_bkt  <= r_bkt + BKTC_W'(1);
                r_slot <= '0;
            end else if (i_cmd.slot_inc) begin
                r_slot <= slot_next;
            end
            if (i_cmd.pend_load) begin
                r_pend <= r_rdata;
                r_cnt  <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.accept) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.pend_load) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_comb begin
        n_out = '{status: STATUS_OK, found_key: '0, found_score: '0, last: 1'b1};
        case (i_cmd.emit_sel)
            EM_OK: ;
            EM_FULL: n_out.status = STATUS_FULL;
            EM_MISS: n_out.status = STATUS_NOT_FOUND;
            EM_RDATA: begin
                n_out.found_key   = r_rdata.key;
                n_out.found_score = r_rdata.score;
            end
            EM_PEND_MID: begin
                n_out.found_key   = r_pend.key;
                n_out.found_score = r_pend.score;
                n_out.last        = 1'b0;
            end
            EM_PEND_LAST: begin
                n_out.found_key   = r_pend.key;
                n_out.found_score = r_pend.score;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- design/chained_hash_table_core.sv -----
// Key/score table with separate chaining: an entry lives in bucket (key mod NUM_BUCKETS),
// up to BUCKET_DEPTH entries per bucket in insertion order, all held in one single-port
// table memory whose read data is registered. Commands are taken one at a time; the input
// is ready only while the controller is idle, and a finished result waits in an output
// register so the next command can start before it is taken. Insert writes the new entry
// at the end of its bucket or reports the bucket full; lookup and delete read the slots of
// the bucket in turn up to the hit or a miss, and a delete hit then moves each later entry
// down one slot and closes the bucket; a range scan reads the buckets in turn and stops
// early after MAX_RESULTS hits, and its results go out as the consumer allows.
// A result that finds the output register still full stalls the walk until it is taken.
// With a bucket count that is not a power of two the bucket index is worked out a nibble
// per cycle for insert, delete and lookup. Bucket fill counts are reset directly, so no
// clearing pass is needed after reset.
`include "chained_hash_table_core_defines.svh"

module chained_hash_table_core import cht_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    cht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    cht_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    `CHT_ASSERT_NOW(a_emit_into_free, dp_cmd.emit, !o_out_valid || i_out_ready, "result overwritten")
    `CHT_ASSERT_NOW(a_idle_no_emit, o_in_ready, !dp_cmd.emit && !dp_cmd.ins_write, "idle activity")
    `CHT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `CHT_ASSERT_NOW(a_one_write, dp_cmd.ins_write, !dp_cmd.shift_wr && !dp_cmd.fill_dec, "write clash")

endmodule
